FILE: hdl/polyline_equal_step_resampler_assert.svh
// Assertion macros shared by the resampler RTL.
`ifndef POLYLINE_EQUAL_STEP_RESAMPLER_ASSERT_SVH
`define POLYLINE_EQUAL_STEP_RESAMPLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PESR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PESR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pesr_pkg.sv
// Package: types and fixed widths of the polyline resampler.
package pesr_pkg;

    localparam int COORD_W = 24;
    localparam int STEP_W  = 8;

    // Sequencer states, one-hot
    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_SUB   = 12'b0000_0000_0010,
        ST_MULX  = 12'b0000_0000_0100,
        ST_MULY  = 12'b0000_0000_1000,
        ST_SUM   = 12'b0000_0001_0000,
        ST_SQRT  = 12'b0000_0010_0000,
        ST_CMP   = 12'b0000_0100_0000,
        ST_MRM   = 12'b0000_1000_0000,
        ST_DIVI  = 12'b0001_0000_0000,
        ST_DIV   = 12'b0010_0000_0000,
        ST_UPD   = 12'b0100_0000_0000,
        ST_FLUSH = 12'b1000_0000_0000
    } state_t;

endpackage

FILE: hdl/polyline_equal_step_resampler.sv
// Top level: fixed arc-length resampler for closed polyline outlines.
// Accepts one vertex at a time; a start vertex emits nothing. Any
// other vertex runs through one shared 24x24 multiplier, a one-bit-per-cycle square root
// and a one-bit-per-cycle divider, run once per axis; the divider takes the largest share
// of the time spent on each emitted point. The block is not ready while a vertex is in work;
// points leave through an output register, so a stalled sink only holds the sequencer
// when a new point must be handed over.
`include "polyline_equal_step_resampler_assert.svh"

module polyline_equal_step_resampler #(
    parameter int MAX_POINTS_PER_VERTEX = 64,
    parameter int FRACTION_BITS         = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // step_size register
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // vertex input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] vertex_x, [47:24] vertex_y
    input  logic        s_tuser,   // outline_start
    // point output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [23:0] point_x, [47:24] point_y
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // truncated
);

    localparam int CW   = pesr_pkg::COORD_W;
    localparam int RW   = pesr_pkg::STEP_W + FRACTION_BITS;   // remaining distance
    localparam int DW   = CW + 1;                              // distance (sqrt result)
    localparam int SQW  = 2 * CW + 2;                          // squared distance
    localparam int NW   = CW + RW + 1;                         // dividend
    localparam int NCW  = $clog2(NW + 1);
    localparam int PCW  = $clog2(MAX_POINTS_PER_VERTEX + 1);
    localparam logic [RW-1:0] RESET_STEP = RW'(4) << FRACTION_BITS;

    pesr_pkg::state_t state_reg, state_next;

    logic [7:0]          step_reg;
    logic signed [CW-1:0] walk_x_reg, walk_x_next, walk_y_reg, walk_y_next;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       vx_reg, vy_reg;
    logic [CW-1:0]       mx_reg, my_reg;
    logic                sx_reg, sy_reg;
    logic [2*CW-1:0]     prod_reg;
    logic [2*CW:0]       acc_reg;
    logic [SQW-1:0]      sq_reg, sq_next, res_reg, res_next, bit_reg, bit_next;
    logic [NW-1:0]       num_reg, num_next;
    logic [DW-1:0]       drem_reg, drem_next;
    logic [NCW-1:0]      dcnt_reg;
    logic                axis_reg;
    logic [CW-1:0]       qx_reg;
    logic [PCW-1:0]      n_reg;
    logic                pend_reg, trunc_reg;
    logic [CW-1:0]       pend_x_reg, pend_y_reg;
    logic                out_valid_reg;
    logic [CW-1:0]       out_x_reg, out_y_reg;
    logic                out_last_reg, out_trunc_reg;

    // Shared datapath signals
    logic [CW:0]      dx, dy;
    logic [CW-1:0]    mul_a, mul_b;
    logic [DW-1:0]    seg_len;
    logic [RW-1:0]    full_step;
    logic             out_free, in_acc, out_load;
    logic [SQW-1:0]   sq_try;
    logic [DW:0]      div_try;
    logic [CW-1:0]    qy;

    assign full_step = RW'(step_reg) << FRACTION_BITS;
    assign out_free  = !out_valid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == pesr_pkg::ST_IDLE);
    assign seg_len   = res_reg[DW-1:0];
    assign dx = {vx_reg[CW-1], vx_reg} - {walk_x_reg[CW-1], walk_x_reg};
    assign dy = {vy_reg[CW-1], vy_reg} - {walk_y_reg[CW-1], walk_y_reg};
    assign sq_try  = res_reg + bit_reg;
    assign div_try = {drem_reg, num_reg[NW-1]};
    assign qy      = num_reg[CW-1:0];

    // Pending point moves to the output register: another point follows, or the vertex closes
    assign out_load = pend_reg && out_free
        && ((state_reg == pesr_pkg::ST_CMP && seg_len > DW'(rem_reg)
             && n_reg < PCW'(MAX_POINTS_PER_VERTEX))
            || state_reg == pesr_pkg::ST_FLUSH);

    // Shared multiplier operand select
    always_comb begin
        mul_a = mx_reg;
        mul_b = mx_reg;
        case (state_reg)
            pesr_pkg::ST_MULY: begin
                mul_a = my_reg;
                mul_b = my_reg;
            end
            pesr_pkg::ST_MRM: begin
                mul_a = axis_reg ? my_reg : mx_reg;
                mul_b = CW'(rem_reg);
            end
            default: begin
                mul_a = mx_reg;
                mul_b = mx_reg;
            end
        endcase
    end

    // Sequencer and datapath next values
    always_comb begin
        state_next  = state_reg;
        walk_x_next = walk_x_reg;
        walk_y_next = walk_y_reg;
        rem_next    = rem_reg;
        sq_next     = sq_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        num_next    = num_reg;
        drem_next   = drem_reg;
        case (state_reg)
            pesr_pkg::ST_IDLE: begin
                if (in_acc && s_tuser) begin
                    walk_x_next = s_tdata[23:0];
                    walk_y_next = s_tdata[47:24];
                    rem_next    = full_step;
                end else if (in_acc) begin
                    state_next = pesr_pkg::ST_SUB;
                end
            end
            pesr_pkg::ST_SUB:  state_next = pesr_pkg::ST_MULX;
            pesr_pkg::ST_MULX: state_next = pesr_pkg::ST_MULY;
            pesr_pkg::ST_MULY: state_next = pesr_pkg::ST_SUM;
            pesr_pkg::ST_SUM: begin
                sq_next    = SQW'(acc_reg) + SQW'(prod_reg);
                res_next   = '0;
                bit_next   = SQW'(1) << (2 * CW);
                state_next = pesr_pkg::ST_SQRT;
            end
            // One result bit per cycle
            pesr_pkg::ST_SQRT: begin
                if (sq_reg >= sq_try) begin
                    sq_next  = sq_reg - sq_try;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == '0) begin
                    res_next   = res_reg;
                    state_next = pesr_pkg::ST_CMP;
                end
            end
            pesr_pkg::ST_CMP: begin
                if (seg_len > DW'(rem_reg)) begin
                    if (n_reg >= PCW'(MAX_POINTS_PER_VERTEX)) begin
                        walk_x_next = vx_reg;
                        walk_y_next = vy_reg;
                        rem_next    = full_step;
                        state_next  = pesr_pkg::ST_FLUSH;
                    end else if (!pend_reg || out_free) begin
                        state_next = pesr_pkg::ST_MRM;
                    end
                end else begin
                    walk_x_next = vx_reg;
                    walk_y_next = vy_reg;
                    rem_next    = rem_reg - seg_len[RW-1:0];
                    state_next  = pesr_pkg::ST_FLUSH;
                end
            end
            pesr_pkg::ST_MRM: state_next = pesr_pkg::ST_DIVI;
            // Dividend with half the divisor for round half up
            pesr_pkg::ST_DIVI: begin
                num_next   = NW'(prod_reg) + NW'(seg_len >> 1);
                drem_next  = '0;
                state_next = pesr_pkg::ST_DIV;
            end
            // Restoring division, one quotient bit per cycle
            pesr_pkg::ST_DIV: begin
                if (div_try >= {1'b0, seg_len}) begin
                    drem_next = DW'(div_try - {1'b0, seg_len});
                    num_next  = {num_reg[NW-2:0], 1'b1};
                end else begin
                    drem_next = div_try[DW-1:0];
                    num_next  = {num_reg[NW-2:0], 1'b0};
                end
                if (dcnt_reg == NCW'(NW - 1)) begin
                    state_next = axis_reg ? pesr_pkg::ST_UPD : pesr_pkg::ST_MRM;
                end
            end
            pesr_pkg::ST_UPD: begin
                walk_x_next = sx_reg ? walk_x_reg - qx_reg : walk_x_reg + qx_reg;
                walk_y_next = sy_reg ? walk_y_reg - qy : walk_y_reg + qy;
                rem_next    = full_step;
                state_next  = pesr_pkg::ST_SUB;
            end
            pesr_pkg::ST_FLUSH: begin
                if (!pend_reg || out_free) begin
                    state_next = pesr_pkg::ST_IDLE;
                end
            end
            default: state_next = pesr_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pesr_pkg::ST_IDLE;
            step_reg      <= 8'd4;
            walk_x_reg    <= '0;
            walk_y_reg    <= '0;
            rem_reg       <= RESET_STEP;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            trunc_reg     <= 1'b0;
            n_reg         <= '0;
            axis_reg      <= 1'b0;
            dcnt_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            walk_x_reg <= walk_x_next;
            walk_y_reg <= walk_y_next;
            rem_reg    <= rem_next;
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                pesr_pkg::ST_IDLE: begin
                    n_reg     <= '0;
                    pend_reg  <= 1'b0;
                    trunc_reg <= 1'b0;
                end
                pesr_pkg::ST_CMP: begin
                    if (seg_len > DW'(rem_reg) && n_reg >= PCW'(MAX_POINTS_PER_VERTEX)) begin
                        trunc_reg <= 1'b1;
                    end else if (out_load) begin
                        // Another point follows: hand over the pending one
                        pend_reg <= 1'b0;
                    end
                    axis_reg <= 1'b0;
                end
                pesr_pkg::ST_DIVI: dcnt_reg <= '0;
                pesr_pkg::ST_DIV: begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == NCW'(NW - 1)) begin
                        axis_reg <= 1'b1;
                    end
                end
                pesr_pkg::ST_UPD: begin
                    pend_reg <= 1'b1;
                    n_reg    <= n_reg + 1'b1;
                end
                pesr_pkg::ST_FLUSH: begin
                    if (out_load) begin
                        pend_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        sq_reg   <= sq_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        num_reg  <= num_next;
        drem_reg <= drem_next;
        prod_reg <= (2*CW)'(mul_a) * (2*CW)'(mul_b);
        if (in_acc) begin
            vx_reg <= s_tdata[23:0];
            vy_reg <= s_tdata[47:24];
        end
        if (state_reg == pesr_pkg::ST_SUB) begin
            sx_reg <= dx[CW];
            sy_reg <= dy[CW];
            mx_reg <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
            my_reg <= dy[CW] ? CW'(-dy) : dy[CW-1:0];
        end
        if (state_reg == pesr_pkg::ST_MULY) begin
            acc_reg <= (2*CW+1)'(prod_reg);
        end
        if (state_reg == pesr_pkg::ST_DIV && dcnt_reg == NCW'(NW - 1) && !axis_reg) begin
            qx_reg <= num_next[CW-1:0];
        end
        if (state_reg == pesr_pkg::ST_UPD) begin
            pend_x_reg <= walk_x_next;
            pend_y_reg <= walk_y_next;
        end
        // Output register load
        if (out_load) begin
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_last_reg  <= (state_reg == pesr_pkg::ST_FLUSH);
            out_trunc_reg <= (state_reg == pesr_pkg::ST_FLUSH) && trunc_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_trunc_reg;

    // Checks
    `PESR_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1,
        n_reg <= PCW'(MAX_POINTS_PER_VERTEX), "point count past limit")
    `PESR_ASSERT_NEXT(a_walk_start, aclk, aresetn, in_acc && !s_tuser,
        state_reg == pesr_pkg::ST_SUB, "non-start vertex did not start walk")
    `PESR_ASSERT_NEXT(a_pend_hold, aclk, aresetn,
        state_reg == pesr_pkg::ST_CMP && pend_reg && !out_free,
        $stable(pend_x_reg) && pend_reg, "pending point lost under stall")
    `PESR_ASSERT_NOW(a_trunc_last, aclk, aresetn, out_valid_reg && out_trunc_reg,
        out_last_reg, "truncated point not last of run")

endmodule

FILE: tb/sv/polyline_equal_step_resampler_checker.sv
// Checker for the polyline resampler: predicts emitted points and compares transfers.
module polyline_equal_step_resampler_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] vertex_x, [47:24] vertex_y
    input  logic        s_tuser,   // outline_start
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [23:0] point_x, [47:24] point_y
    input  logic        m_tlast,   // last_of_run
    input  logic        m_tuser,   // truncated
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS   = 64;
    localparam int FRAC_BITS = 8;

    typedef struct {
        logic [23:0] px;
        logic [23:0] py;
        logic        last_run;
        logic        trunc;
    } point_t;

    point_t            expected_points[$];
    logic [7:0]        step_q;
    longint signed     walk_x, walk_y;
    longint unsigned   remain_dist;

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Floor of the square root, one result bit per pass
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // delta * r / d, magnitude rounded half up, sign of delta kept
    function automatic longint signed scale_move(longint signed delta,
                                                 longint unsigned r, longint unsigned d);
        longint unsigned a, m;
        a = (delta < 0) ? longint'(-delta) : longint'(delta);
        m = (a * r + d / 2) / d;
        return (delta < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned full_step();
        return longint'(step_q) << FRAC_BITS;
    endfunction

    // Walk toward one vertex and queue the points it causes
    task automatic walk_vertex(logic [47:0] data, logic start);
        longint signed   vx, vy, dx, dy;
        longint unsigned ax, ay, seg_len;
        int              n;
        point_t          p;
        vx = longint'($signed(data[23:0]));
        vy = longint'($signed(data[47:24]));
        n  = 0;
        if (start) begin
            walk_x      = vx;
            walk_y      = vy;
            remain_dist = full_step();
            return;
        end
        forever begin
            dx      = vx - walk_x;
            dy      = vy - walk_y;
            ax      = (dx < 0) ? longint'(-dx) : longint'(dx);
            ay      = (dy < 0) ? longint'(-dy) : longint'(dy);
            seg_len = root_floor(ax * ax + ay * ay);
            if (seg_len > remain_dist) begin
                if (n >= MAX_PTS) begin
                    expected_points[expected_points.size() - 1].trunc = 1'b1;
                    walk_x      = vx;
                    walk_y      = vy;
                    remain_dist = full_step();
                    break;
                end
                walk_x     += scale_move(dx, remain_dist, seg_len);
                walk_y     += scale_move(dy, remain_dist, seg_len);
                p.px        = walk_x[23:0];
                p.py        = walk_y[23:0];
                p.last_run  = 1'b0;
                p.trunc     = 1'b0;
                expected_points.insert(expected_points.size(), p);
                n++;
                remain_dist = full_step();
            end else begin
                walk_x       = vx;
                walk_y       = vy;
                remain_dist -= seg_len;
                break;
            end
        end
        if (n > 0) expected_points[expected_points.size() - 1].last_run = 1'b1;
    endtask

    always @(posedge aclk) begin
        point_t exp_pt;
        if (!aresetn) begin
            step_q      = 8'd4;
            walk_x      = 0;
            walk_y      = 0;
            remain_dist = longint'(4) << FRAC_BITS;
            expected_points.delete();
        end else begin
            if (cfg_wr_en) step_q = cfg_wr_data;
            if (s_tvalid && s_tready) walk_vertex(s_tdata, s_tuser);
            // compare each point transfer with the oldest expectation
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("unexpected point %h", m_tdata));
                end else begin
                    exp_pt = expected_points.pop_front();
                    if (m_tdata[23:0] !== exp_pt.px)
                        report_mismatch($sformatf("point_x %h, want %h",
                                                  m_tdata[23:0], exp_pt.px));
                    if (m_tdata[47:24] !== exp_pt.py)
                        report_mismatch($sformatf("point_y %h, want %h",
                                                  m_tdata[47:24], exp_pt.py));
                    if (m_tlast !== exp_pt.last_run)
                        report_mismatch($sformatf("last_of_run %b, want %b",
                                                  m_tlast, exp_pt.last_run));
                    if (m_tuser !== exp_pt.trunc)
                        report_mismatch($sformatf("truncated %b, want %b",
                                                  m_tuser, exp_pt.trunc));
                end
            end
        end
        pending <= expected_points.size();
    end
endmodule

FILE: tb/sv/tb_polyline_equal_step_resampler.sv
// Testbench top: drives vertices and step sizes into the resampler and gives the verdict.
module tb_polyline_equal_step_resampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SETTLE_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int  VMAX = 8388607;
    localparam int  VMIN = -8388608;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid, s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid, m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast, m_tuser;
    int          fail_count, pending;
    int          src_idle, sink_stall;
    longint      cycles = 0;
    logic [7:0]  cur_step;
    longint      cur_x, cur_y;

    always #6 aclk = ~aclk;

    polyline_equal_step_resampler dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    polyline_equal_step_resampler_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sink backpressure
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else          m_tready <= ($urandom_range(99) >= sink_stall);
    end

    function automatic longint clamp_coord(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // One vertex transfer; tvalid stays up for a back-to-back follower
    task automatic push_vertex(longint x, longint y, logic start);
        logic [pesr_pkg::COORD_W-1:0] xs, ys;
        xs = x[pesr_pkg::COORD_W-1:0];
        ys = y[pesr_pkg::COORD_W-1:0];
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ys, xs};
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        cur_x = x;
        cur_y = y;
    endtask

    // Drain all points, then let a vertex with no points finish
    task automatic drain_block();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_step(logic [7:0] val);
        drain_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_step = val;
    endtask

    // Random outlines: full-range start, then mostly short hops with random content
    task automatic random_phase(int count);
        int     sent, mode;
        longint span;
        sent = 0;
        while (sent < count) begin
            push_vertex(longint'($signed($urandom_range(24'hFFFFFF, 0) & 24'hFFFFFF)) - 0,
                        0, 1'b1);
            push_vertex(longint'($signed(24'($urandom()))),
                        longint'($signed(24'($urandom()))), 1'b1);
            sent += 2;
            repeat ($urandom_range(12, 1)) begin
                mode = $urandom_range(99);
                if (mode < 80)      span = longint'(cur_step) * 256 * 3;
                else if (mode < 85) span = longint'(cur_step) * 256 * 90;
                else                span = 0;
                if (mode >= 95) begin
                    // noise: any vertex at all
                    push_vertex(longint'($signed(24'($urandom()))),
                                longint'($signed(24'($urandom()))), 1'b0);
                end else begin
                    push_vertex(
                        clamp_coord(cur_x + longint'($urandom_range(2 * span)) - span),
                        clamp_coord(cur_y + longint'($urandom_range(2 * span)) - span),
                        1'b0);
                end
                sent++;
            end
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 8'd0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        src_idle    = 0;
        sink_stall  = 0;
        cur_step    = 8'd4;
        cur_x       = 0;
        cur_y       = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: vertex before any outline start, landing exactly on the step
        push_vertex(1024, 0, 1'b0);
        // zero remaining distance repeats the walk position
        push_vertex(2048, 0, 1'b0);
        // vertex equal to the walk position
        push_vertex(2048, 0, 1'b0);
        push_vertex(0, 0, 1'b1);
        push_vertex(5000, -3000, 1'b0);
        push_vertex(-700, 2600, 1'b0);
        // back-to-back outline starts
        push_vertex(100, 100, 1'b1);
        push_vertex(-100, -100, 1'b1);
        push_vertex(-100, 900, 1'b0);
        // corner to corner: truncation
        push_vertex(VMAX, VMAX, 1'b1);
        push_vertex(VMIN, VMIN, 1'b0);
        push_vertex(VMIN, VMAX, 1'b1);
        push_vertex(VMAX, VMIN, 1'b0);
        write_step(8'd1);
        push_vertex(0, 0, 1'b1);
        push_vertex(256 * 70, 0, 1'b0);
        push_vertex(256 * 70, 256 * 3, 1'b0);
        write_step(8'd255);
        push_vertex(VMAX, 0, 1'b1);
        push_vertex(VMAX - 255 * 256 * 5, -300, 1'b0);
        push_vertex(VMIN, 0, 1'b0);

        // Random phases across step sizes and idling patterns
        for (int ph = 0; ph < 5; ph++) begin
            case (ph % 4)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 55; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 55; end
                default: begin src_idle = 22; sink_stall = 22; end
            endcase
            case (ph)
                0: write_step(8'd4);
                1: write_step(8'd1);
                2: write_step(8'd255);
                3: write_step(8'($urandom_range(254, 1)));
                default: write_step(8'($urandom_range(16, 2)));
            endcase
            random_phase(100);
        end

        drain_block();
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
